// ----- src/permutation_rank_unrank_top_defines.svh -----
// Assertion macros for the permutation rank/unrank block.
// Included by the RTL modules that carry concurrent assertions.
`ifndef PERMUTATION_RANK_UNRANK_TOP_DEFINES_SVH
`define PERMUTATION_RANK_UNRANK_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PRU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PRU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/perm_ru_pkg.sv -----
// Package for the permutation rank/unrank block: widths, codes, state type.
// No dependencies.
`default_nettype none

package perm_ru_pkg;

   localparam int unsigned TABLE_DEPTH = 16;
   localparam int unsigned ADDR_W      = 4;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned INDEX_W     = 64;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned NUM_DIGITS  = INDEX_W / DIGIT_W;
   localparam int unsigned BIT_CNT_W   = 6;
   localparam int unsigned DIG_CNT_W   = 4;
   localparam int unsigned CARRY_W     = 5;
   localparam int unsigned DTOT_W      = 9;

   localparam logic CMD_UNRANK = 1'b0;
   localparam logic CMD_RANK   = 1'b1;
   localparam logic KIND_ELEM  = 1'b0;
   localparam logic KIND_RANK  = 1'b1;

   typedef logic [ADDR_W-1:0] elem_type;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DIV     = 9'b000000010,
      ST_RD_SLOT = 9'b000000100,
      ST_RD_LAST = 9'b000001000,
      ST_EMIT    = 9'b000010000,
      ST_R_READ  = 9'b000100000,
      ST_R_MUL   = 9'b001000000,
      ST_R_WRITE = 9'b010000000,
      ST_R_DONE  = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

// ----- src/permutation_rank_unrank_top.sv -----
// Permutation rank/unrank top level: bit-serial divider, digit-serial
// multiply-accumulate and the slot, position and scratch tables.
// Depends on perm_ru_pkg and permutation_rank_unrank_top_defines.svh.
//
// Usage: the req_ channel carries commands. An unrank command (req_command 0)
// carries n (req_count, clamped to 1..min(MAX_ELEMS,16)) and req_perm_index;
// the block answers with n element transfers on the rsp_ channel, the last
// one flagged rsp_end_of_run. Rank items (req_command 1) stream the
// permutation one element each; only the item with req_final_req set gets a
// transfer back, carrying the rank in rsp_out_index.
// Timing: one item is taken at a time (req_ready high only when idle).
// Each unranked element needs a restoring division of the 64-bit index, one
// bit per cycle, then the scratch reads in ST_RD_SLOT and ST_RD_LAST and the
// swap and output write in ST_EMIT, which waits for a free output register.
// A rank item runs ST_R_READ, the 16 four-bit digit steps of the weight
// multiply-accumulate in ST_R_MUL, ST_R_WRITE and ST_R_DONE; a surplus element
// goes from ST_R_READ to ST_R_DONE. A final item's result is written in ST_R_DONE.
// Reset: the tables read as identity and no rank stream is open; no clearing
// pass is needed. Stalls: the result sits in an output register; the block
// holds each new result until rsp_ready takes the pending transfer.
`default_nettype none
`include "permutation_rank_unrank_top_defines.svh"

module permutation_rank_unrank_top
   import perm_ru_pkg::*;
#(
   parameter int unsigned MAX_ELEMS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic [COUNT_W-1:0] req_count,
   input  wire logic [INDEX_W-1:0] req_perm_index,
   input  wire logic [ADDR_W-1:0]  req_element,
   input  wire logic               req_final_req,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_kind,
   output logic [ADDR_W-1:0]       rsp_out_element,
   output logic [INDEX_W-1:0]      rsp_out_index,
   output logic                    rsp_end_of_run
);

   localparam int unsigned LIMIT_INT = (MAX_ELEMS < TABLE_DEPTH) ? MAX_ELEMS : TABLE_DEPTH;
   localparam logic [COUNT_W-1:0] ELEM_LIMIT = COUNT_W'(LIMIT_INT);

   // control and datapath registers
   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      n_ff, n_in;
   logic [COUNT_W-1:0]      i_ff, i_in;
   logic [COUNT_W-1:0]      step_ff, step_in;
   logic                    rank_active_ff, rank_active_in;
   logic [INDEX_W-1:0]      m_ff, m_in;
   logic [ADDR_W-1:0]       rem_ff, rem_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]    dig_cnt_ff, dig_cnt_in;
   elem_type                slot_elem_ff, slot_elem_in;
   elem_type                elem_ff, elem_in;
   logic                    final_ff, final_in;
   logic [INDEX_W-1:0]      sum_ff, sum_in;
   logic [INDEX_W-1:0]      wgt_ff, wgt_in;
   logic [CARRY_W-1:0]      sum_c_ff, sum_c_in;
   logic [CARRY_W-1:0]      wgt_c_ff, wgt_c_in;
   logic [TABLE_DEPTH-1:0]  scr_vld_ff, scr_vld_in;
   logic [TABLE_DEPTH-1:0]  pos_vld_ff, pos_vld_in;
   logic [TABLE_DEPTH-1:0]  slt_vld_ff, slt_vld_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   elem_type                rsp_elem_ff, rsp_elem_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                    rsp_end_ff, rsp_end_in;

   // memories with registered reads
   elem_type                scr_mem [TABLE_DEPTH];
   elem_type                pos_mem [TABLE_DEPTH];
   elem_type                slt_mem [TABLE_DEPTH];
   elem_type                scr_rd_ff, pos_rd_ff, slt_rd_ff;
   logic                    scr_re, scr_we, rank_re, rank_we;
   elem_type                scr_raddr;

   // combinational helpers
   logic                    req_xfer, out_free;
   logic [COUNT_W-1:0]      clamp_n;
   logic [COUNT_W-1:0]      div_radix, mul_radix;
   logic [ADDR_W:0]         div_shift, div_diff;
   logic                    div_ge;
   elem_type                unrank_last, rank_last;
   logic [7:0]              s_prod;
   logic [DTOT_W-1:0]       s_tot, w_tot;

   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // clamp the element count to 1..limit
   always_comb begin
      if (req_count == '0) begin
         clamp_n = COUNT_W'(1);
      end else if (req_count > ELEM_LIMIT) begin
         clamp_n = ELEM_LIMIT;
      end else begin
         clamp_n = req_count;
      end
   end

   assign div_radix   = n_ff - i_ff;
   assign mul_radix   = n_ff - step_ff;
   assign unrank_last = ADDR_W'(n_ff - i_ff - COUNT_W'(1));
   assign rank_last   = ADDR_W'(n_ff - step_ff - COUNT_W'(1));

   // one restoring division step: shift in the next index bit
   assign div_shift = {rem_ff, m_ff[INDEX_W-1]};
   assign div_ge    = (div_shift >= div_radix);
   assign div_diff  = div_shift - div_radix;

   // one digit of sum += wgt * p and wgt *= radix
   assign s_prod = 8'(wgt_ff[DIGIT_W-1:0]) * 8'(pos_rd_ff);
   assign s_tot  = DTOT_W'(s_prod) + DTOT_W'(sum_ff[DIGIT_W-1:0]) + DTOT_W'(sum_c_ff);
   assign w_tot  = DTOT_W'(wgt_ff[DIGIT_W-1:0]) * DTOT_W'(mul_radix) + DTOT_W'(wgt_c_ff);

   // sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      i_in           = i_ff;
      step_in        = step_ff;
      rank_active_in = rank_active_ff;
      m_in           = m_ff;
      rem_in         = rem_ff;
      bit_cnt_in     = bit_cnt_ff;
      dig_cnt_in     = dig_cnt_ff;
      slot_elem_in   = slot_elem_ff;
      elem_in        = elem_ff;
      final_in       = final_ff;
      sum_in         = sum_ff;
      wgt_in         = wgt_ff;
      sum_c_in       = sum_c_ff;
      wgt_c_in       = wgt_c_ff;
      scr_vld_in     = scr_vld_ff;
      pos_vld_in     = pos_vld_ff;
      slt_vld_in     = slt_vld_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_elem_in    = rsp_elem_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_end_in     = rsp_end_ff;
      scr_re         = 1'b0;
      scr_we         = 1'b0;
      scr_raddr      = rem_ff;
      rank_re        = 1'b0;
      rank_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               n_in     = clamp_n;
               elem_in  = req_element;
               final_in = req_final_req;
               if (req_command == CMD_UNRANK) begin
                  m_in       = req_perm_index;
                  i_in       = '0;
                  rem_in     = '0;
                  bit_cnt_in = '0;
                  scr_vld_in = '0;
                  state_in   = ST_DIV;
               end else begin
                  // open a new stream: identity tables, zero sum, unit weight
                  if (!rank_active_ff) begin
                     pos_vld_in     = '0;
                     slt_vld_in     = '0;
                     sum_in         = '0;
                     wgt_in         = INDEX_W'(1);
                     step_in        = '0;
                     rank_active_in = 1'b1;
                  end
                  state_in = ST_R_READ;
               end
            end
         end
         ST_DIV: begin
            rem_in     = div_ge ? div_diff[ADDR_W-1:0] : div_shift[ADDR_W-1:0];
            m_in       = {m_ff[INDEX_W-2:0], div_ge};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == '1) begin
               state_in = ST_RD_SLOT;
            end
         end
         ST_RD_SLOT: begin
            scr_re    = 1'b1;
            scr_raddr = rem_ff;
            state_in  = ST_RD_LAST;
         end
         ST_RD_LAST: begin
            slot_elem_in = scr_rd_ff;
            scr_re       = 1'b1;
            scr_raddr    = unrank_last;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // emit the slot element, move the last live element into the slot
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_kind_in         = KIND_ELEM;
               rsp_elem_in         = slot_elem_ff;
               rsp_index_in        = '0;
               rsp_end_in          = ((i_ff + COUNT_W'(1)) == n_ff);
               scr_we              = 1'b1;
               scr_vld_in[rem_ff]  = 1'b1;
               i_in                = i_ff + COUNT_W'(1);
               rem_in              = '0;
               bit_cnt_in          = '0;
               state_in            = ((i_ff + COUNT_W'(1)) == n_ff) ? ST_IDLE : ST_DIV;
            end
         end
         ST_R_READ: begin
            rank_re    = 1'b1;
            dig_cnt_in = '0;
            sum_c_in   = '0;
            wgt_c_in   = '0;
            state_in   = ((step_ff + COUNT_W'(1)) < n_ff) ? ST_R_MUL : ST_R_DONE;
         end
         ST_R_MUL: begin
            sum_in     = {s_tot[DIGIT_W-1:0], sum_ff[INDEX_W-1:DIGIT_W]};
            wgt_in     = {w_tot[DIGIT_W-1:0], wgt_ff[INDEX_W-1:DIGIT_W]};
            sum_c_in   = s_tot[DTOT_W-1:DIGIT_W];
            wgt_c_in   = w_tot[DTOT_W-1:DIGIT_W];
            dig_cnt_in = dig_cnt_ff + DIG_CNT_W'(1);
            if (dig_cnt_ff == DIG_CNT_W'(NUM_DIGITS - 1)) begin
               state_in = ST_R_WRITE;
            end
         end
         ST_R_WRITE: begin
            rank_we               = 1'b1;
            pos_vld_in[slt_rd_ff] = 1'b1;
            slt_vld_in[pos_rd_ff] = 1'b1;
            step_in               = step_ff + COUNT_W'(1);
            state_in              = ST_R_DONE;
         end
         ST_R_DONE: begin
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_RANK;
               rsp_elem_in    = '0;
               rsp_index_in   = sum_ff;
               rsp_end_in     = 1'b1;
               rank_active_in = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rank_active_ff <= 1'b0;
         step_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         scr_vld_ff     <= '0;
         pos_vld_ff     <= '0;
         slt_vld_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         rank_active_ff <= rank_active_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
         scr_vld_ff     <= scr_vld_in;
         pos_vld_ff     <= pos_vld_in;
         slt_vld_ff     <= slt_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      m_ff         <= m_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      dig_cnt_ff   <= dig_cnt_in;
      slot_elem_ff <= slot_elem_in;
      elem_ff      <= elem_in;
      final_ff     <= final_in;
      sum_ff       <= sum_in;
      wgt_ff       <= wgt_in;
      sum_c_ff     <= sum_c_in;
      wgt_c_ff     <= wgt_c_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_index_ff <= rsp_index_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // scratch table for unranking; an unwritten entry reads as its address
   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[rem_ff] <= scr_rd_ff;
      end
      if (scr_re) begin
         scr_rd_ff <= scr_vld_ff[scr_raddr] ? scr_mem[scr_raddr] : scr_raddr;
      end
   end

   // position table: element -> slot
   always_ff @(posedge clock) begin
      if (rank_we) begin
         pos_mem[slt_rd_ff] <= pos_rd_ff;
      end
      if (rank_re) begin
         pos_rd_ff <= pos_vld_ff[elem_ff] ? pos_mem[elem_ff] : elem_ff;
      end
   end

   // slot table: slot -> element
   always_ff @(posedge clock) begin
      if (rank_we) begin
         slt_mem[pos_rd_ff] <= slt_rd_ff;
      end
      if (rank_re) begin
         slt_rd_ff <= slt_vld_ff[rank_last] ? slt_mem[rank_last] : rank_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_element = rsp_elem_ff;
   assign rsp_out_index   = rsp_index_ff;
   assign rsp_end_of_run  = rsp_end_ff;

   // checks
   `PRU_ASSERT_SAME(a_rem_below_radix, clock, reset, state_ff == ST_DIV, rem_ff < div_radix, "division remainder not below radix")
   `PRU_ASSERT_SAME(a_step_in_range, clock, reset, state_ff == ST_DIV, i_ff < n_ff, "unrank step beyond element count")
   `PRU_ASSERT_NEXT(a_stream_open, clock, reset, req_xfer && req_command == CMD_RANK && !rank_active_ff, rank_active_ff && step_ff == '0, "rank stream did not open")
   `PRU_ASSERT_SAME(a_rank_ends_run, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_RANK, rsp_end_ff, "rank result without end of run")

endmodule

`default_nettype wire

// ----- tb/permutation_rank_unrank_checker.sv -----
// Scoreboard for the permutation rank/unrank block: watches both channels,
// predicts every result from its own copy of the tables, and counts mismatches.
// Depends on perm_ru_pkg.
module permutation_rank_unrank_checker
   import perm_ru_pkg::*;
#(
   parameter int unsigned MAX_ELEMS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_command,
   input  wire logic [COUNT_W-1:0] req_count,
   input  wire logic [INDEX_W-1:0] req_perm_index,
   input  wire logic [ADDR_W-1:0]  req_element,
   input  wire logic               req_final_req,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic               rsp_kind,
   input  wire logic [ADDR_W-1:0]  rsp_out_element,
   input  wire logic [INDEX_W-1:0] rsp_out_index,
   input  wire logic               rsp_end_of_run,
   output int                      mismatch_count,
   output int                      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               kind;
      elem_type           element;
      logic [INDEX_W-1:0] index;
      logic               last;
   } perm_result_type;

   perm_result_type    pending_results[$];
   elem_type           slot_of[TABLE_DEPTH];
   elem_type           position_of[TABLE_DEPTH];
   logic [INDEX_W-1:0] rank_acc;
   logic [INDEX_W-1:0] weight;
   int unsigned        steps_done;
   bit                 stream_open;
   int                 errors = 0;

   assign mismatch_count = errors;

   // Clamp a requested count to the number of live elements
   function automatic int unsigned live_count(logic [COUNT_W-1:0] c);
      int unsigned lim;
      lim = (MAX_ELEMS < TABLE_DEPTH) ? MAX_ELEMS : TABLE_DEPTH;
      if (c == 0) return 1;
      if (c > lim) return lim;
      return c;
   endfunction

   // Reload identity tables and clear the running rank
   task automatic open_stream();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_of[i]     = elem_type'(i);
         position_of[i] = elem_type'(i);
      end
      rank_acc   = '0;
      weight     = 64'd1;
      steps_done = 0;
   endtask

   // Expand an index into n element transfers, swapping the last live slot in
   task automatic unrank_index(logic [COUNT_W-1:0] c, logic [INDEX_W-1:0] idx);
      elem_type           scratch[TABLE_DEPTH];
      logic [INDEX_W-1:0] rest;
      logic [INDEX_W-1:0] radix;
      int unsigned        n;
      elem_type           slot;
      perm_result_type    r;
      n    = live_count(c);
      rest = idx;
      for (int i = 0; i < TABLE_DEPTH; i++) scratch[i] = elem_type'(i);
      for (int unsigned i = 0; i < n; i++) begin
         radix     = INDEX_W'(n - i);
         slot      = elem_type'(rest % radix);
         rest      = rest / radix;
         r.kind    = KIND_ELEM;
         r.element = scratch[slot];
         r.index   = '0;
         r.last    = (i + 1 == n);
         pending_results.push_back(r);
         scratch[slot] = scratch[elem_type'(n - i - 1)];
      end
   endtask

   // Fold one streamed element into the rank; the final one yields the index
   task automatic rank_element(logic [COUNT_W-1:0] c, elem_type e, logic fin);
      int unsigned     n;
      int unsigned     i;
      elem_type        p;
      elem_type        last_elem;
      perm_result_type r;
      n = live_count(c);
      if (!stream_open) begin
         open_stream();
         stream_open = 1'b1;
      end
      i = steps_done;
      // surplus elements leave everything as is
      if (i + 1 < n) begin
         p         = position_of[e];
         last_elem = slot_of[elem_type'(n - i - 1)];
         rank_acc  = rank_acc + weight * INDEX_W'(p);
         weight    = weight * INDEX_W'(n - i);
         position_of[last_elem] = p;
         slot_of[p]             = last_elem;
         steps_done             = i + 1;
      end
      if (fin) begin
         r.kind    = KIND_RANK;
         r.element = '0;
         r.index   = rank_acc;
         r.last    = 1'b1;
         pending_results.push_back(r);
         stream_open = 1'b0;
      end
   endtask

   task automatic report_mismatch(string what, logic [INDEX_W-1:0] got,
                                  logic [INDEX_W-1:0] want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
   endtask

   // Check result transfers first, then predict from the request transfer
   always @(posedge clock) begin
      perm_result_type want;
      if (reset) begin
         open_stream();
         stream_open = 1'b0;
         pending_results.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result transfer with nothing pending", rsp_out_index, '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", INDEX_W'(rsp_kind), INDEX_W'(want.kind));
               if (rsp_out_element !== want.element)
                  report_mismatch("out_element", INDEX_W'(rsp_out_element),
                                  INDEX_W'(want.element));
               if (rsp_out_index !== want.index)
                  report_mismatch("out_index", rsp_out_index, want.index);
               if (rsp_end_of_run !== want.last)
                  report_mismatch("end_of_run", INDEX_W'(rsp_end_of_run),
                                  INDEX_W'(want.last));
            end
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_UNRANK)
               unrank_index(req_count, req_perm_index);
            else
               rank_element(req_count, req_element, req_final_req);
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

// ----- tb/tb.sv -----
// Top of the permutation rank/unrank testbench: clock, reset, request and
// result traffic, and the verdict. Depends on perm_ru_pkg, the block and
// permutation_rank_unrank_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import perm_ru_pkg::*;

   localparam int unsigned ELEM_LIMIT  = 16;
   localparam int          CYCLE_LIMIT = 4_000_000;
   localparam int          HOLD_CYCLES = 1500;
   localparam int          TAIL_CYCLES = 200;
   localparam int          ITEM_TARGET = 440;

   typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKED} rx_mode_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_command    = CMD_UNRANK;
   logic [COUNT_W-1:0] req_count      = '0;
   logic [INDEX_W-1:0] req_perm_index = '0;
   logic [ADDR_W-1:0]  req_element    = '0;
   logic               req_final_req  = 1'b0;
   logic               rsp_ready      = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_kind;
   logic [ADDR_W-1:0]  rsp_out_element;
   logic [INDEX_W-1:0] rsp_out_index;
   logic               rsp_end_of_run;
   int                 mismatch_count;
   int                 outstanding;

   bit hold_request = 1'b0;
   int burst_left   = 0;
   int items_sent   = 0;
   int cycles       = 0;

   permutation_rank_unrank_top #(.MAX_ELEMS(ELEM_LIMIT)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_count(req_count),
      .req_perm_index(req_perm_index), .req_element(req_element),
      .req_final_req(req_final_req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind), .rsp_out_element(rsp_out_element),
      .rsp_out_index(rsp_out_index), .rsp_end_of_run(rsp_end_of_run)
   );

   permutation_rank_unrank_checker #(.MAX_ELEMS(ELEM_LIMIT)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_count(req_count),
      .req_perm_index(req_perm_index), .req_element(req_element),
      .req_final_req(req_final_req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind), .rsp_out_element(rsp_out_element),
      .rsp_out_index(rsp_out_index), .rsp_end_of_run(rsp_end_of_run),
      .mismatch_count(mismatch_count), .outstanding(outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Mostly small counts, some large, a few out of range
   function automatic logic [COUNT_W-1:0] pick_count();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return COUNT_W'($urandom_range(1, 8));
      if (r < 17) return COUNT_W'($urandom_range(9, 16));
      if (r == 17) return '0;
      return COUNT_W'($urandom_range(17, 31));
   endfunction

   function automatic int unsigned span_of(logic [COUNT_W-1:0] c);
      if (c == 0) return 1;
      if (c > ELEM_LIMIT) return ELEM_LIMIT;
      return c;
   endfunction

   // Offer one request, idling between bursts; valid stays up for the next one
   task automatic offer(logic cmd, logic [COUNT_W-1:0] cnt, logic [INDEX_W-1:0] idx,
                        logic [ADDR_W-1:0] elem, logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_count      <= cnt;
      req_perm_index <= idx;
      req_element    <= elem;
      req_final_req  <= fin;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Result side: stall patterns that change now and then, one long hold-off
   initial begin : result_side
      rx_mode_type mode;
      int          mode_left;
      int          phase;
      bit          hold_done;
      mode_left = 0;
      phase     = 0;
      hold_done = 1'b0;
      mode      = RX_OPEN;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            phase++;
            case (mode)
               RX_OPEN:     rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_ready <= (phase % 4 != 0);
               default:     rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [COUNT_W-1:0] cnt;
      logic [INDEX_W-1:0] idx;
      logic [INDEX_W-1:0] lim;
      elem_type           perm[TABLE_DEPTH];
      elem_type           swap;
      int unsigned        len;
      int                 j;
      int                 pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Unrank extremes: zero count, single element, full size, clamped counts
      offer(CMD_UNRANK, 5'd0,  64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
      offer(CMD_UNRANK, 5'd1,  64'd0, 4'd15, 1'b1);
      offer(CMD_UNRANK, 5'd16, 64'd0, 4'd0, 1'b0);
      offer(CMD_UNRANK, 5'd16, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
      offer(CMD_UNRANK, 5'd31, 64'd20922789887999, 4'd0, 1'b0);
      offer(CMD_UNRANK, 5'd17, {$urandom, $urandom}, 4'd0, 1'b0);
      offer(CMD_UNRANK, 5'd2,  64'd1, 4'd0, 1'b0);
      // Single-element stream, then a clean stream of three
      offer(CMD_RANK, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
      offer(CMD_RANK, 5'd3, 64'd0, 4'd2, 1'b0);
      offer(CMD_RANK, 5'd3, 64'd0, 4'd0, 1'b0);
      offer(CMD_RANK, 5'd3, 64'd0, 4'd1, 1'b1);
      // Unrank inside an open stream, foreign element, count change, surplus
      offer(CMD_RANK,   5'd3, 64'd0,  4'd1,  1'b0);
      offer(CMD_UNRANK, 5'd4, 64'd23, 4'd0,  1'b0);
      offer(CMD_RANK,   5'd3, 64'd0,  4'd15, 1'b0);
      offer(CMD_RANK,   5'd5, 64'd0,  4'd7,  1'b0);
      offer(CMD_RANK,   5'd2, 64'd0,  4'd0,  1'b1);
      // Stream opened and closed by a single item with a zero count
      offer(CMD_RANK,   5'd0, 64'd0,  4'd15, 1'b1);
      offer(CMD_UNRANK, 5'd5, 64'd119, 4'd0, 1'b0);

      hold_request <= 1'b1;

      // Random traffic: unranks, well-formed streams, broken streams
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         cnt  = pick_count();
         len  = span_of(cnt);
         if (pick < 40) begin
            case ($urandom_range(0, 3))
               0: idx = {$urandom, $urandom};
               1: idx = INDEX_W'($urandom_range(0, 5000));
               2: begin
                  lim = 64'd1;
                  for (int unsigned k = 2; k <= len; k++) lim = lim * k;
                  idx = {$urandom, $urandom} % lim;
               end
               default: idx = ~INDEX_W'($urandom_range(0, 3));
            endcase
            offer(CMD_UNRANK, cnt, idx, 4'($urandom), 1'($urandom));
         end else if (pick < 85) begin
            for (int unsigned k = 0; k < len; k++) perm[k] = elem_type'(k);
            for (int unsigned k = len - 1; k > 0; k--) begin
               j       = $urandom_range(0, k);
               swap    = perm[k];
               perm[k] = perm[j];
               perm[j] = swap;
            end
            for (int unsigned k = 0; k < len; k++)
               offer(CMD_RANK, cnt, {$urandom, $urandom}, perm[k], k == len - 1);
         end else begin
            len = $urandom_range(1, 6);
            for (int unsigned k = 0; k < len; k++) begin
               offer(CMD_RANK, ($urandom_range(0, 2) == 0) ? pick_count() : cnt,
                     {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                     (k == len - 1) && ($urandom_range(0, 1) == 1));
            end
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow a trailing rank step to finish
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
